[hw/rtl/epcs_pkg.sv]
// ----------------------------------------------------------------------------
// epcs_pkg: eight-phase control sequencer definitions
// Word types for the tick and control channels, opcodes and control line bits.
// ----------------------------------------------------------------------------
package epcs_pkg;

	localparam int unsigned PhaseW = 3;
	localparam int unsigned OpW    = 8;
	localparam int unsigned AccW   = 8;
	localparam int unsigned CwW    = 14;
	localparam int unsigned SelW   = 3;

	typedef struct packed {
		logic            restart;
		logic [OpW-1:0]  instr_code;
		logic [AccW-1:0] accum_value;
	} tick_t;

	typedef struct packed {
		logic [PhaseW-1:0] phase_now;
		logic [CwW-1:0]    control_word;
		logic [SelW-1:0]   reg_select;
	} ctrl_t;

	// phases
	localparam logic [PhaseW-1:0] PH_T1 = 3'd0;
	localparam logic [PhaseW-1:0] PH_T2 = 3'd1;
	localparam logic [PhaseW-1:0] PH_T3 = 3'd2;
	localparam logic [PhaseW-1:0] PH_T4 = 3'd3;
	localparam logic [PhaseW-1:0] PH_T5 = 3'd4;
	localparam logic [PhaseW-1:0] PH_T6 = 3'd5;
	localparam logic [PhaseW-1:0] PH_T7 = 3'd6;
	localparam logic [PhaseW-1:0] PH_T8 = 3'd7;

	// opcodes
	localparam logic [OpW-1:0] OP_LDA     = 8'h01;
	localparam logic [OpW-1:0] OP_ADD     = 8'h02;
	localparam logic [OpW-1:0] OP_JMP     = 8'h03;
	localparam logic [OpW-1:0] OP_JZ      = 8'h04;
	localparam logic [OpW-1:0] OP_ALU_M1  = 8'h05;
	localparam logic [OpW-1:0] OP_ALU_M2  = 8'h06;
	localparam logic [OpW-1:0] OP_ALU_M3  = 8'h07;
	localparam logic [OpW-1:0] OP_ALU_M4  = 8'h08;
	localparam logic [OpW-1:0] OP_ALU_ACC = 8'h09;
	localparam logic [OpW-1:0] OP_ALU_M5  = 8'h0A;
	localparam logic [OpW-1:0] OP_ALU_M6  = 8'h0B;
	localparam logic [OpW-1:0] OP_IF      = 8'h0C;
	localparam logic [OpW-1:0] OP_STA     = 8'h0D;
	localparam logic [OpW-1:0] OP_OUT     = 8'h0E;
	localparam logic [OpW-1:0] OP_LDR_LO  = 8'h10;
	localparam logic [OpW-1:0] OP_LDR_HI  = 8'h17;
	localparam logic [OpW-1:0] OP_STR_LO  = 8'h18;
	localparam logic [OpW-1:0] OP_STR_HI  = 8'h1F;
	localparam logic [OpW-1:0] OP_ADDR_LO = 8'h20;
	localparam logic [OpW-1:0] OP_ADDR_HI = 8'h27;

	// control word bits
	localparam logic [CwW-1:0] CW_PC_INC    = 14'h0001;
	localparam logic [CwW-1:0] CW_PC_OUT    = 14'h0002;
	localparam logic [CwW-1:0] CW_PC_LOAD   = 14'h0004;
	localparam logic [CwW-1:0] CW_MAR_LOAD  = 14'h0008;
	localparam logic [CwW-1:0] CW_IR_LOAD   = 14'h0010;
	localparam logic [CwW-1:0] CW_RAM_OUT   = 14'h0020;
	localparam logic [CwW-1:0] CW_RAM_WRITE = 14'h0040;
	localparam logic [CwW-1:0] CW_ACC_LOAD  = 14'h0080;
	localparam logic [CwW-1:0] CW_ACC_OUT   = 14'h0100;
	localparam logic [CwW-1:0] CW_REGB_LOAD = 14'h0200;
	localparam logic [CwW-1:0] CW_ALU_OUT   = 14'h0400;
	localparam logic [CwW-1:0] CW_OUT_LOAD  = 14'h0800;
	localparam logic [CwW-1:0] CW_RF_WRITE  = 14'h1000;
	localparam logic [CwW-1:0] CW_RF_OUT    = 14'h2000;

endpackage

[hw/rtl/eight_phase_control_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// eight_phase_control_sequencer_unit
// Steps a T1..T8 phase counter once per tick word (or returns it to T1 on restart)
// and emits the control lines for the current phase and opcode.
//
//   channel  direction  word     handshake
//   tick     in         tick_t   tick_valid / tick_stall
//   ctrl     out        ctrl_t   ctrl_valid / ctrl_stall
//
// One tick word per cycle while tick_stall is low; each word passes an input
// register and a result register. The decode between them is a small opcode/phase table.
// Reset puts the phase at T1 and empties both registers.
// A stalled ctrl word holds; tick_stall rises only when both registers are
// full and ctrl is stalled.
// ----------------------------------------------------------------------------
module eight_phase_control_sequencer_unit
	import epcs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  tick_valid,
	output logic  tick_stall,
	input  tick_t tick,
	output logic  ctrl_valid,
	input  logic  ctrl_stall,
	output ctrl_t ctrl
);

	logic              valid_s1;
	tick_t             tick_s1;
	logic              valid_s2;
	ctrl_t             ctrl_s2;
	logic [PhaseW-1:0] phase_q;

	logic              adv_s1;
	logic              load_s1;
	logic              takes_opnd;
	logic              alu_mem;
	logic              acc_zero;
	logic              is_ldr;
	logic              is_str;
	logic              is_addr;
	logic [OpW-1:0]    op;
	logic [CwW-1:0]    cw;
	logic [SelW-1:0]   sel;
	logic [CwW-1:0]    jump_cw;

	assign adv_s1     = valid_s1 && (!valid_s2 || !ctrl_stall);
	assign tick_stall = valid_s1 && !adv_s1;
	assign load_s1    = tick_valid && !tick_stall;

	assign op       = tick_s1.instr_code;
	assign acc_zero = (tick_s1.accum_value == '0);

	assign takes_opnd = (op >= OP_LDA && op <= OP_ALU_M4) ||
		(op >= OP_ALU_M5 && op <= OP_STA) || (op >= OP_LDR_LO && op <= OP_STR_HI);
	assign alu_mem = (op == OP_ADD) || (op == OP_ALU_M1) || (op == OP_ALU_M2) ||
		(op == OP_ALU_M3) || (op == OP_ALU_M4) || (op == OP_ALU_M5) ||
		(op == OP_ALU_M6);
	assign is_ldr  = (op >= OP_LDR_LO) && (op <= OP_LDR_HI);
	assign is_str  = (op >= OP_STR_LO) && (op <= OP_STR_HI);
	assign is_addr = (op >= OP_ADDR_LO) && (op <= OP_ADDR_HI);

	// T5: taken jump loads the pc from the operand, else skip past the operand
	always_comb begin
		if ((op == OP_JMP) || (op == OP_JZ && acc_zero) || (op == OP_IF && !acc_zero)) begin
			jump_cw = CW_PC_LOAD | CW_MAR_LOAD;
		end else begin
			jump_cw = CW_PC_INC | CW_MAR_LOAD;
		end
	end

	always_comb begin
		cw  = '0;
		sel = '0;
		case (phase_q)
			PH_T1: cw = CW_PC_OUT | CW_MAR_LOAD;
			PH_T2: cw = CW_PC_INC;
			PH_T3: cw = CW_RAM_OUT | CW_IR_LOAD;
			PH_T4: begin
				if (takes_opnd) begin
					cw = CW_PC_OUT | CW_MAR_LOAD;
				end else if (op == OP_ALU_ACC) begin
					cw = CW_ALU_OUT | CW_ACC_LOAD;
				end else if (op == OP_OUT) begin
					cw = CW_ACC_OUT | CW_OUT_LOAD;
				end
			end
			PH_T5: begin
				if (takes_opnd) begin
					cw = CW_RAM_OUT | jump_cw;
				end
			end
			PH_T6: cw = '0;
			PH_T7: begin
				if (is_ldr) begin
					cw  = CW_RAM_OUT | CW_RF_WRITE;
					sel = op[SelW-1:0];
				end else if (is_str) begin
					cw  = CW_RF_OUT | CW_RAM_WRITE;
					sel = op[SelW-1:0];
				end else if (is_addr) begin
					cw  = CW_RF_OUT | CW_REGB_LOAD;
					sel = op[SelW-1:0];
				end else if (op == OP_LDA) begin
					cw = CW_RAM_OUT | CW_ACC_LOAD;
				end else if (alu_mem) begin
					cw = CW_RAM_OUT | CW_REGB_LOAD;
				end else if (op == OP_STA) begin
					cw = CW_ACC_OUT | CW_RAM_WRITE;
				end
			end
			PH_T8: begin
				if (is_addr || alu_mem) begin
					cw = CW_ALU_OUT | CW_ACC_LOAD;
				end
			end
			default: cw = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_T1;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				phase_q  <= tick_s1.restart ? PH_T1 : phase_q + 1'b1;
			end else if (!ctrl_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			tick_s1 <= tick;
		end
		if (adv_s1) begin
			ctrl_s2.phase_now    <= phase_q;
			ctrl_s2.control_word <= cw;
			ctrl_s2.reg_select   <= sel;
		end
	end

	assign ctrl_valid = valid_s2;
	assign ctrl       = ctrl_s2;

endmodule
